>>> sv/mi3_pkg.sv
// shared widths, types and index helpers for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

    localparam int ELEM_W     = 16;
    localparam int NELEM      = 9;
    localparam int COF_W      = 33;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = ELEM_W + COF_W;
    localparam int DET_W      = 51;
    localparam int DMAG_W     = DET_W - 1;
    localparam int REM_W      = DMAG_W + 1;
    localparam int QUO_W      = 33;
    localparam int OUT_W      = 32;
    localparam int FRAC_SHIFT = 24;
    localparam int PRE_SHIFT  = QUO_W - FRAC_SHIFT;

    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(33'h0_7FFF_FFFF);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(33'h0_8000_0000);
    localparam logic [OUT_W-1:0] OUT_MAX   = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN   = 32'h8000_0000;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic              singular;
        logic [DMAG_W-1:0] det_mag;
    } det_info_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } lane_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } quo_t;

    function automatic int idx_lo(input int r);
        return (r == 0) ? 1 : 0;
    endfunction

    function automatic int idx_hi(input int r);
        return (r == 2) ? 1 : 2;
    endfunction

endpackage

>>> sv/mi3_front.sv
// cofactor, determinant and magnitude stages (three register stages)
// depends on mi3_pkg
module mi3_front
    import mi3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  elem_t     m [NELEM],
    output logic      out_valid,
    output det_info_t info,
    output lane_t     lanes [NELEM]
);

    logic                     va_reg, vb_reg, vc_reg;
    logic signed [COF_W-1:0]  cof_next [NELEM];
    logic signed [COF_W-1:0]  cof_reg  [NELEM];
    logic signed [COF_W-1:0]  cofb_reg [NELEM];
    elem_t                    a0_reg   [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [DET_W-1:0]  det;
    det_info_t                info_next, info_reg;
    lane_t                    lane_next [NELEM];
    lane_t                    lane_reg  [NELEM];

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            localparam int R1 = idx_lo(gr);
            localparam int R2 = idx_hi(gr);
            localparam int C1 = idx_lo(gc);
            localparam int C2 = idx_hi(gc);
            logic signed [2*ELEM_W-1:0] p1, p2;
            logic signed [COF_W-1:0]    d;
            assign p1 = m[R1*3+C1] * m[R2*3+C2];
            assign p2 = m[R2*3+C1] * m[R1*3+C2];
            assign d  = COF_W'(p1) - COF_W'(p2);
            if (((gr + gc) % 2) == 1) begin : g_neg
                assign cof_next[gr*3+gc] = -d;
            end
            else begin : g_pos
                assign cof_next[gr*3+gc] = d;
            end
        end
    end

    assign det = DET_W'(prod_reg[0]) + DET_W'(prod_reg[1]) + DET_W'(prod_reg[2]);

    always_comb
    begin
        logic signed [DET_W-1:0] dabs;
        dabs = det[DET_W-1] ? -det : det;
        info_next.singular = (det == '0);
        info_next.det_mag  = dabs[DMAG_W-1:0];
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_oi
        for (genvar gj = 0; gj < 3; gj++) begin : g_oj
            logic signed [COF_W-1:0] c;
            logic signed [COF_W-1:0] cabs;
            assign c    = cofb_reg[gj*3+gi];
            assign cabs = c[COF_W-1] ? -c : c;
            assign lane_next[gi*3+gj].neg = c[COF_W-1] ^ det[DET_W-1];
            assign lane_next[gi*3+gj].mag = cabs[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                cof_reg[k]  <= cof_next[k];
                cofb_reg[k] <= cof_reg[k];
                lane_reg[k] <= lane_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                a0_reg[k]   <= m[k];
                prod_reg[k] <= a0_reg[k] * cof_reg[k];
            end
            info_reg <= info_next;
        end
    end

    assign out_valid = vc_reg;
    assign info      = info_reg;
    assign lanes     = lane_reg;

endmodule

>>> sv/mi3_div.sv
// nine-lane pipelined restoring divider, one quotient bit per stage
// depends on mi3_pkg
module mi3_div
    import mi3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  det_info_t info,
    input  lane_t     lanes [NELEM],
    output logic      out_valid,
    output logic      singular,
    output quo_t      quos [NELEM]
);

    logic                  v_reg    [QUO_W+1];
    det_info_t             info_reg [QUO_W+1];
    logic [REM_W-1:0]      rem_reg  [QUO_W+1][NELEM];
    logic [PRE_SHIFT-1:0]  low_reg  [QUO_W+1][NELEM];
    quo_t                  q_reg    [QUO_W+1][NELEM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QUO_W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= QUO_W; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // overflow check on the top dividend bits
    for (genvar l = 0; l < NELEM; l++) begin : g_first
        logic [MAG_W-PRE_SHIFT-1:0] head;
        assign head = lanes[l].mag[MAG_W-1:PRE_SHIFT];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0][l]   <= REM_W'(head);
                low_reg[0][l]   <= lanes[l].mag[PRE_SHIFT-1:0];
                q_reg[0][l].neg <= lanes[l].neg;
                q_reg[0][l].ovf <= (DMAG_W'(head) >= info.det_mag);
                q_reg[0][l].quo <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info_reg[0] <= info;
            for (int s = 1; s <= QUO_W; s++)
            begin
                info_reg[s] <= info_reg[s-1];
            end
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
        localparam int K = QUO_W - s;
        for (genvar l = 0; l < NELEM; l++) begin : g_lane
            logic             b;
            logic [REM_W-1:0] t;
            logic             ge;
            quo_t             qn;
            if (K >= FRAC_SHIFT) begin : g_bit
                assign b = low_reg[s-1][l][K-FRAC_SHIFT];
            end
            else begin : g_zero
                assign b = 1'b0;
            end
            assign t  = {rem_reg[s-1][l][REM_W-2:0], b};
            assign ge = (t >= REM_W'(info_reg[s-1].det_mag));
            always_comb
            begin
                qn        = q_reg[s-1][l];
                qn.quo[K] = ge;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= ge ? t - REM_W'(info_reg[s-1].det_mag) : t;
                    low_reg[s][l] <= low_reg[s-1][l];
                    q_reg[s][l]   <= qn;
                end
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign singular  = info_reg[QUO_W].singular;
    assign quos      = q_reg[QUO_W];

endmodule

>>> sv/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by the adjugate, top level
// depends on mi3_pkg, mi3_front, mi3_div
//
// input stream: one transaction per matrix, nine signed Q8.8 elements in
// s_axis_tdata, row-major, a00 in the lowest 16 bits.
// output stream: one transaction per matrix, nine signed Q16.16 inverse
// elements in m_axis_tdata row-major, inv00 lowest; m_axis_tuser carries
// the singular and saturated flags.
// the pipeline has three cofactor/determinant stages, one overflow
// check, 33 divider stages (one quotient bit each) and the output register.
// throughput is one matrix per cycle unless the receiver stalls; the divider chain sets the depth.
// when the receiver stalls, the whole pipeline holds and s_axis_tready
// drops until the output register is taken; nothing is lost or repeated.
// reset empties the pipeline; the block holds no other state.
module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [ELEM_W*NELEM-1:0]  s_axis_tdata,  // a00 a01 a02 a10 a11 a12 a20 a21 a22
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_W*NELEM-1:0]   m_axis_tdata,  // inv00 inv01 ... inv22
    output logic [1:0]               m_axis_tuser   // singular saturated
);

    logic                   en;
    elem_t                  m [NELEM];
    logic                   front_valid;
    det_info_t              info;
    lane_t                  lanes [NELEM];
    logic                   div_valid;
    logic                   div_singular;
    quo_t                   quos [NELEM];
    logic [OUT_W*NELEM-1:0] data_next, data_reg;
    logic [NELEM-1:0]       sat_vec;
    logic                   valid_reg;
    logic [1:0]             user_reg;

    assign en            = !valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    for (genvar k = 0; k < NELEM; k++) begin : g_in
        assign m[k] = s_axis_tdata[k*ELEM_W +: ELEM_W];
    end

    mi3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .m         (m),
        .out_valid (front_valid),
        .info      (info),
        .lanes     (lanes)
    );

    mi3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .info      (info),
        .lanes     (lanes),
        .out_valid (div_valid),
        .singular  (div_singular),
        .quos      (quos)
    );

    // sign, saturation and singular forcing
    for (genvar k = 0; k < NELEM; k++) begin : g_out
        logic             sat;
        logic [OUT_W-1:0] val;
        assign sat = quos[k].ovf ||
                     (quos[k].quo > (quos[k].neg ? NEG_LIMIT : POS_LIMIT));
        always_comb
        begin
            if (sat)
            begin
                val = quos[k].neg ? OUT_MIN : OUT_MAX;
            end
            else if (quos[k].neg)
            begin
                val = -quos[k].quo[OUT_W-1:0];
            end
            else
            begin
                val = quos[k].quo[OUT_W-1:0];
            end
        end
        assign sat_vec[k] = sat;
        assign data_next[k*OUT_W +: OUT_W] = div_singular ? '0 : val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            user_reg <= {!div_singular && (|sat_vec), div_singular};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("singular result with nonzero elements");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("singular and saturated both set");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(div_valid))
        else $error("output valid without a divider result");

endmodule
